// ===== sv/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types, codes and helpers shared by the WebSocket unmask / base64 decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_DONE  = 2'd1,
		EV_CLOSE = 2'd2,
		EV_ERROR = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_LEN64    = 3'd1,
		ERR_UNMASKED = 3'd2,
		ERR_BADCHAR  = 3'd3,
		ERR_SHORT    = 3'd4,
		ERR_LEFTOVER = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_DONE = 2'd2
	} pad_t;

	typedef struct packed {
		logic [1:0] qpos;
		logic [7:0] carry;
		pad_t       pad;
		logic       text_ended;
	} dec_state_t;

	typedef struct packed {
		dec_state_t nxt;
		logic       has;
		logic [7:0] ob;
		logic       bad;
	} dec_out_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		event_t     event_res;
		logic [3:0] event_opcode;
		err_t       error_code;
	} res_t;

	// bit 6 set when the character is in the base64 alphabet
	function automatic logic [6:0] sextet(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		if (c >= "A" && c <= "Z") begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= "a" && c <= "z") begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= "0" && c <= "9") begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == "+") begin
			r = {1'b1, 6'd62};
		end else if (c == "/") begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ===== sv/wsfd_if.sv =====
// ----------------------------------------------------------------------------
// wsfd_if
// Valid/ready channels of the decoder: raw stream bytes in, results out.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] out_byte;
	logic [1:0] event_res;
	logic [3:0] event_opcode;
	logic [2:0] error_code;

	modport source (output valid, output has_byte, output out_byte, output event_res,
		output event_opcode, output error_code, input ready);
	modport sink   (input valid, input has_byte, input out_byte, input event_res,
		input event_opcode, input error_code, output ready);
endinterface

// ===== sv/ws_frame_unmask_base64_decoder.sv =====
// ----------------------------------------------------------------------------
// ws_frame_unmask_base64_decoder
// WebSocket client frame parser with payload unmasking and base64 decoding.
// ----------------------------------------------------------------------------
// Usage:
//   frame   : sink of raw stream bytes, one byte per request.
//   decoded : source of results. A result carries a decoded byte (has_byte),
//             a frame event (data frame done, close seen, error) or both.
//             Header bytes, skipped frames and whitespace give no result.
//   A byte is held in an input register, then parsed, unmasked and decoded
//   in a single pass into the result register, which offers the result.
//   One byte is taken every cycle while the receiver does not stall; the
//   rate is set by the combinational header/decode pass.
//   When the receiver stalls the result register holds its contents and the
//   input stage stops taking bytes once it is full; nothing is dropped.
//   Reset clears the parser to expect a frame's first header byte. A close
//   frame or any error halts the block: further bytes are taken and ignored
//   until reset.
// ----------------------------------------------------------------------------
module ws_frame_unmask_base64_decoder import wsfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wsfd_in_if.sink     frame,
	wsfd_out_if.source  decoded
);

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t          phase_q;
	logic [1:0]      cnt_q;
	logic [3:0]      opc_q;
	logic            mask_q;
	logic [15:0]     plen_q;
	logic [15:0]     pidx_q;
	logic [3:0][7:0] key_q;
	dec_state_t      dec_q;
	logic            skip_q;
	logic            halt_q;

	phase_t          phase_d;
	logic [1:0]      cnt_d;
	logic [3:0]      opc_d;
	logic            mask_d;
	logic [15:0]     plen_d;
	logic [15:0]     pidx_d;
	logic [3:0][7:0] key_d;
	dec_state_t      dec_d;
	logic            skip_d;
	logic            halt_d;

	// result register
	logic out_vld_q;
	res_t out_q;
	logic res_vld;
	res_t res;

	logic        out_free;
	logic        go;
	logic [7:0]  chr;
	dec_out_t    dec_o;
	logic [16:0] idx_inc;
	logic        last;
	logic        do_after_len;
	logic        do_hdr_done;
	logic [15:0] len_v;
	logic        mask_v;

	assign out_free    = !out_vld_q || decoded.ready;
	assign go          = vld_s1 && out_free;
	assign frame.ready = !vld_s1 || out_free;

	assign chr     = byte_s1 ^ key_q[pidx_q[1:0]];
	assign idx_inc = {1'b0, pidx_q} + 17'd1;
	assign last    = idx_inc >= {1'b0, plen_q};

	wsfd_b64 u_b64 (
		.chr (chr),
		.cur (dec_q),
		.res (dec_o)
	);

	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		opc_d        = opc_q;
		mask_d       = mask_q;
		plen_d       = plen_q;
		pidx_d       = pidx_q;
		key_d        = key_q;
		dec_d        = dec_q;
		skip_d       = skip_q;
		halt_d       = halt_q;
		res_vld      = 1'b0;
		res          = '0;
		do_after_len = 1'b0;
		do_hdr_done  = 1'b0;
		len_v        = plen_q;
		mask_v       = mask_q;

		if (!halt_q) begin
			case (phase_q)
				PH_FIRST: begin
					opc_d   = byte_s1[3:0];
					phase_d = PH_SECOND;
				end
				PH_SECOND: begin
					mask_d = byte_s1[7];
					mask_v = byte_s1[7];
					if (opc_q == OP_CLOSE) begin
						halt_d           = 1'b1;
						res_vld          = 1'b1;
						res.event_res    = EV_CLOSE;
						res.event_opcode = opc_q;
					end else if (byte_s1[6:0] == LEN_EXT64) begin
						halt_d           = 1'b1;
						res_vld          = 1'b1;
						res.event_res    = EV_ERROR;
						res.event_opcode = opc_q;
						res.error_code   = ERR_LEN64;
					end else if (byte_s1[6:0] == LEN_EXT16) begin
						plen_d  = '0;
						cnt_d   = '0;
						phase_d = PH_EXTLEN;
					end else begin
						plen_d       = {9'b0, byte_s1[6:0]};
						len_v        = {9'b0, byte_s1[6:0]};
						do_after_len = 1'b1;
					end
				end
				PH_EXTLEN: begin
					plen_d = {plen_q[7:0], byte_s1};
					len_v  = {plen_q[7:0], byte_s1};
					cnt_d  = cnt_q + 2'd1;
					if (cnt_q == 2'd1) begin
						do_after_len = 1'b1;
					end
				end
				PH_KEY: begin
					key_d[cnt_q] = byte_s1;
					cnt_d        = cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						do_hdr_done = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					pidx_d = idx_inc[15:0];
					if (skip_q) begin
						if (last) begin
							skip_d  = 1'b0;
							phase_d = PH_FIRST;
						end
					end else if (dec_o.bad) begin
						halt_d           = 1'b1;
						res_vld          = 1'b1;
						res.event_res    = EV_ERROR;
						res.event_opcode = opc_q;
						res.error_code   = ERR_BADCHAR;
					end else begin
						dec_d        = dec_o.nxt;
						res.has_byte = dec_o.has;
						res.out_byte = dec_o.has ? dec_o.ob : 8'h00;
						res_vld      = dec_o.has;
						if (last) begin
							phase_d          = PH_FIRST;
							res_vld          = 1'b1;
							res.event_opcode = opc_q;
							res.event_res    = EV_DONE;
							if (dec_o.nxt.pad == PAD_NONE && dec_o.nxt.qpos != 2'd0) begin
								res.error_code = ERR_SHORT;
							end else if (dec_o.nxt.pad == PAD_ONE) begin
								res.error_code = ERR_BADCHAR;
							end else if (dec_o.nxt.pad == PAD_DONE && dec_o.nxt.carry != 8'h00) begin
								res.error_code = ERR_LEFTOVER;
							end
							if (res.error_code != ERR_NONE) begin
								res.event_res = EV_ERROR;
								halt_d        = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_FIRST;
				end
			endcase

			if (do_after_len) begin
				cnt_d = '0;
				if (mask_v) begin
					key_d   = '0;
					phase_d = PH_KEY;
				end else begin
					do_hdr_done = 1'b1;
				end
			end

			if (do_hdr_done) begin
				pidx_d = '0;
				if (len_v == 16'd0) begin
					phase_d = PH_FIRST;
				end else if (opc_q != OP_TEXT && opc_q != OP_BINARY) begin
					skip_d  = 1'b1;
					phase_d = PH_PAYLOAD;
				end else if (!mask_v) begin
					halt_d           = 1'b1;
					res_vld          = 1'b1;
					res.event_res    = EV_ERROR;
					res.event_opcode = opc_q;
					res.error_code   = ERR_UNMASKED;
				end else begin
					skip_d  = 1'b0;
					dec_d   = '0;
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (frame.ready) begin
			vld_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			cnt_q   <= '0;
			opc_q   <= '0;
			mask_q  <= 1'b0;
			plen_q  <= '0;
			pidx_q  <= '0;
			key_q   <= '0;
			dec_q   <= '0;
			skip_q  <= 1'b0;
			halt_q  <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			opc_q   <= opc_d;
			mask_q  <= mask_d;
			plen_q  <= plen_d;
			pidx_q  <= pidx_d;
			key_q   <= key_d;
			dec_q   <= dec_d;
			skip_q  <= skip_d;
			halt_q  <= halt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= go && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_vld) begin
			out_q <= res;
		end
	end

	assign decoded.valid        = out_vld_q;
	assign decoded.has_byte     = out_q.has_byte;
	assign decoded.out_byte     = out_q.out_byte;
	assign decoded.event_res    = out_q.event_res;
	assign decoded.event_opcode = out_q.event_opcode;
	assign decoded.error_code   = out_q.error_code;

endmodule

// ===== sv/wsfd_b64.sv =====
// ----------------------------------------------------------------------------
// wsfd_b64
// One step of the base64 decoder for an unmasked payload character.
// ----------------------------------------------------------------------------
module wsfd_b64 import wsfd_pkg::*; (
	input  logic [7:0] chr,
	input  dec_state_t cur,
	output dec_out_t   res
);

	logic [6:0] sx;

	assign sx = sextet(chr);

	always_comb begin
		res     = '0;
		res.nxt = cur;
		if (!cur.text_ended) begin
			if (chr == 8'h00) begin
				res.nxt.text_ended = 1'b1;
			end else if (chr == 8'h20 || (chr >= 8'h09 && chr <= 8'h0d)) begin
				// whitespace skipped
			end else if (cur.pad == PAD_DONE) begin
				res.bad = 1'b1;
			end else if (cur.pad == PAD_ONE) begin
				if (chr != "=") begin
					res.bad = 1'b1;
				end else begin
					res.nxt.pad = PAD_DONE;
				end
			end else if (chr == "=") begin
				if (cur.qpos < 2'd2) begin
					res.bad = 1'b1;
				end else begin
					res.nxt.pad = (cur.qpos == 2'd2) ? PAD_ONE : PAD_DONE;
				end
			end else if (!sx[6]) begin
				res.bad = 1'b1;
			end else begin
				case (cur.qpos)
					2'd0: begin
						res.nxt.carry = {sx[5:0], 2'b00};
						res.nxt.qpos  = 2'd1;
					end
					2'd1: begin
						res.ob        = cur.carry | {6'b0, sx[5:4]};
						res.nxt.carry = {sx[3:0], 4'b0};
						res.has       = 1'b1;
						res.nxt.qpos  = 2'd2;
					end
					2'd2: begin
						res.ob        = cur.carry | {4'b0, sx[5:2]};
						res.nxt.carry = {sx[1:0], 6'b0};
						res.has       = 1'b1;
						res.nxt.qpos  = 2'd3;
					end
					default: begin
						res.ob        = cur.carry | {2'b0, sx[5:0]};
						res.nxt.carry = '0;
						res.has       = 1'b1;
						res.nxt.qpos  = 2'd0;
					end
				endcase
			end
		end
	end

endmodule

// ===== sim/ws_frame_unmask_base64_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws_frame_unmask_base64_decoder_test
// Feeds client WebSocket frames byte by byte: base64 text and binary frames
// with random masks and whitespace, skipped control and empty frames, then
// one frame that stops the block. Every result is checked against a local
// parser/decoder model, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module ws_frame_unmask_base64_decoder_test;
	import wsfd_pkg::*;

	localparam logic [3:0] OP_PING = 4'h9;

	typedef struct packed {
		logic       hold;
		logic [7:0] b;
	} tx_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	wsfd_in_if  frame_if ();
	wsfd_out_if res_if ();

	ws_frame_unmask_base64_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_if),
		.decoded (res_if)
	);

	logic       src_valid = 1'b0;
	logic [7:0] src_byte = 8'h00;
	logic       snk_ready = 1'b0;

	assign frame_if.valid   = src_valid;
	assign frame_if.in_byte = src_byte;
	assign res_if.ready     = snk_ready;

	tx_t        tx_q[$];
	logic [7:0] text_q[$];
	res_t       decoded_due[$];
	int         mismatches = 0;
	int         res_seen = 0;

	// parser and decoder state
	phase_t      ph;
	logic [2:0]  hdr_cnt;
	logic [3:0]  f_op;
	logic        masked;
	logic [15:0] plen;
	logic [15:0] pidx;
	logic [31:0] key;
	logic [1:0]  qpos;
	logic [7:0]  carry;
	pad_t        pad;
	logic        txt_done;
	logic        skipping;
	logic        stopped;

	function automatic int alphabet_index(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'("A");
		if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
		if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		return -1;
	endfunction

	function automatic logic [7:0] alphabet_char(input logic [5:0] v);
		if (v < 26) return 8'("A") + 8'(v);
		if (v < 52) return 8'("a") + 8'(v) - 8'd26;
		if (v < 62) return 8'("0") + 8'(v) - 8'd52;
		if (v == 62) return "+";
		return "/";
	endfunction

	task automatic parser_reset();
		ph = PH_FIRST;
		hdr_cnt = '0;
		f_op = '0;
		masked = 1'b0;
		plen = '0;
		pidx = '0;
		key = '0;
		qpos = '0;
		carry = '0;
		pad = PAD_NONE;
		txt_done = 1'b0;
		skipping = 1'b0;
		stopped = 1'b0;
	endtask

	task automatic queue_result(input logic has, input logic [7:0] ob, input event_t ev,
		input logic [3:0] op, input err_t er);
		res_t r;
		r.has_byte = has;
		r.out_byte = has ? ob : 8'h00;
		r.event_res = ev;
		r.event_opcode = (ev != EV_NONE) ? op : 4'h0;
		r.error_code = (ev == EV_ERROR) ? er : ERR_NONE;
		decoded_due.push_back(r);
	endtask

	task automatic halt_on(input err_t er);
		stopped = 1'b1;
		queue_result(1'b0, 8'h00, EV_ERROR, f_op, er);
	endtask

	task automatic header_end();
		pidx = '0;
		if (plen == 0) begin
			ph = PH_FIRST;
		end else if (f_op != OP_TEXT && f_op != OP_BINARY) begin
			skipping = 1'b1;
			ph = PH_PAYLOAD;
		end else if (!masked) begin
			halt_on(ERR_UNMASKED);
		end else begin
			skipping = 1'b0;
			qpos = '0;
			carry = '0;
			pad = PAD_NONE;
			txt_done = 1'b0;
			ph = PH_PAYLOAD;
		end
	endtask

	task automatic length_known();
		hdr_cnt = '0;
		if (masked) begin
			key = '0;
			ph = PH_KEY;
		end else begin
			header_end();
		end
	endtask

	task automatic payload_in(input logic [7:0] b);
		logic [15:0] idx;
		logic        last;
		logic        got;
		logic [7:0]  c;
		logic [7:0]  ob;
		int          v;
		err_t        er;
		idx = pidx;
		last = ({1'b0, idx} + 17'd1) >= {1'b0, plen};
		pidx = idx + 16'd1;
		got = 1'b0;
		ob = 8'h00;
		er = ERR_NONE;
		if (skipping) begin
			if (last) begin
				skipping = 1'b0;
				ph = PH_FIRST;
			end
			return;
		end
		c = b ^ key[8 * idx[1:0] +: 8];
		if (!txt_done) begin
			if (c == 8'h00) begin
				txt_done = 1'b1;
			end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
				// whitespace
			end else if (pad == PAD_DONE) begin
				halt_on(ERR_BADCHAR);
				return;
			end else if (pad == PAD_ONE) begin
				if (c != "=") begin
					halt_on(ERR_BADCHAR);
					return;
				end
				pad = PAD_DONE;
			end else if (c == "=") begin
				if (qpos < 2) begin
					halt_on(ERR_BADCHAR);
					return;
				end
				pad = (qpos == 2'd2) ? PAD_ONE : PAD_DONE;
			end else begin
				v = alphabet_index(c);
				if (v < 0) begin
					halt_on(ERR_BADCHAR);
					return;
				end
				case (qpos)
					2'd0: begin
						carry = {v[5:0], 2'b00};
						qpos = 2'd1;
					end
					2'd1: begin
						ob = carry | {6'd0, v[5:4]};
						carry = {v[3:0], 4'd0};
						got = 1'b1;
						qpos = 2'd2;
					end
					2'd2: begin
						ob = carry | {4'd0, v[5:2]};
						carry = {v[1:0], 6'd0};
						got = 1'b1;
						qpos = 2'd3;
					end
					default: begin
						ob = carry | {2'd0, v[5:0]};
						carry = '0;
						got = 1'b1;
						qpos = 2'd0;
					end
				endcase
			end
		end
		if (!last) begin
			if (got) queue_result(1'b1, ob, EV_NONE, 4'h0, ERR_NONE);
			return;
		end
		ph = PH_FIRST;
		if (pad == PAD_NONE && qpos != 0) er = ERR_SHORT;
		else if (pad == PAD_ONE) er = ERR_BADCHAR;
		else if (pad == PAD_DONE && carry != 0) er = ERR_LEFTOVER;
		if (er != ERR_NONE) begin
			stopped = 1'b1;
			queue_result(got, ob, EV_ERROR, f_op, er);
		end else begin
			queue_result(got, ob, EV_DONE, f_op, ERR_NONE);
		end
	endtask

	task automatic step_parser(input logic [7:0] b);
		if (stopped) return;
		case (ph)
			PH_FIRST: begin
				f_op = b[3:0];
				ph = PH_SECOND;
			end
			PH_SECOND: begin
				masked = b[7];
				if (f_op == OP_CLOSE) begin
					stopped = 1'b1;
					queue_result(1'b0, 8'h00, EV_CLOSE, f_op, ERR_NONE);
				end else if (b[6:0] == LEN_EXT64) begin
					halt_on(ERR_LEN64);
				end else if (b[6:0] == LEN_EXT16) begin
					plen = '0;
					hdr_cnt = '0;
					ph = PH_EXTLEN;
				end else begin
					plen = {9'd0, b[6:0]};
					length_known();
				end
			end
			PH_EXTLEN: begin
				plen = {plen[7:0], b};
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt >= 3'd2) length_known();
			end
			PH_KEY: begin
				key = key | ({24'd0, b} << (8 * hdr_cnt[1:0]));
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt >= 3'd4) header_end();
			end
			PH_PAYLOAD: payload_in(b);
			default: ph = PH_FIRST;
		endcase
	endtask

	// stimulus building
	task automatic push_byte(input logic [7:0] b);
		tx_q.push_back('{hold: 1'b0, b: b});
	endtask

	task automatic hold_sender();
		tx_q.push_back('{hold: 1'b1, b: 8'h00});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	task automatic maybe_space(input int pct);
		int k;
		if ($urandom_range(0, 99) < pct) begin
			k = $urandom_range(0, 5);
			text_q.push_back((k == 5) ? 8'h20 : 8'(8'h09 + k));
		end
	endtask

	task automatic add_b64(input int n, input int ws_pct);
		int          k;
		logic [23:0] w;
		for (int i = 0; i < n; i += 3) begin
			k = (n - i >= 3) ? 3 : n - i;
			w = {8'($urandom), (k > 1) ? 8'($urandom) : 8'h00, (k > 2) ? 8'($urandom) : 8'h00};
			for (int j = 0; j < 4; j++) begin
				maybe_space(ws_pct);
				text_q.push_back((j <= k) ? alphabet_char(w[23 - 6 * j -: 6]) : 8'("="));
			end
		end
		maybe_space(ws_pct);
	endtask

	task automatic send_frame(input logic [3:0] op, input logic mbit, input logic ext,
		input logic [31:0] k);
		int n;
		n = text_q.size();
		push_byte({4'($urandom), op});
		if (ext || n >= 126) begin
			push_byte({mbit, LEN_EXT16});
			push_byte(8'(n >> 8));
			push_byte(8'(n));
		end else begin
			push_byte({mbit, 7'(n)});
		end
		if (mbit) for (int i = 0; i < 4; i++) push_byte(k[8 * i +: 8]);
		for (int i = 0; i < n; i++) push_byte(mbit ? text_q[i] ^ k[8 * (i % 4) +: 8] : text_q[i]);
		text_q.delete();
	endtask

	function automatic logic [3:0] data_op();
		return $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
	endfunction

	// sender
	logic src_calm = 1'b0;
	int   src_gap = 0;
	tx_t  src_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_byte <= 8'h00;
			src_gap <= 0;
			src_calm <= 1'b0;
			parser_reset();
		end else begin
			if (src_valid && frame_if.ready) step_parser(src_byte);
			if (!src_valid || frame_if.ready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					src_valid <= 1'b0;
				end else if (tx_q.size() != 0 && tx_q[0].hold) begin
					src_valid <= 1'b0;
					if (decoded_due.size() == 0) void'(tx_q.pop_front());
				end else if (tx_q.size() != 0) begin
					src_next = tx_q.pop_front();
					src_valid <= 1'b1;
					src_byte <= src_next.b;
					if ($urandom_range(0, 47) == 0) src_calm <= !src_calm;
					src_gap <= src_calm ? 0 : int'($urandom_range(0, 3));
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	logic snk_calm = 1'b0;
	int   snk_wait = 0;
	int   snk_next;

	task automatic check_result();
		res_t want;
		res_seen++;
		if (decoded_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("request %0d: unexpected result has=%0d byte=%02h ev=%0d op=%0d err=%0d",
					res_seen, res_if.has_byte, res_if.out_byte, res_if.event_res,
					res_if.event_opcode, res_if.error_code);
			return;
		end
		want = decoded_due.pop_front();
		if (res_if.has_byte !== want.has_byte || res_if.out_byte !== want.out_byte ||
			res_if.event_res !== want.event_res || res_if.event_opcode !== want.event_opcode ||
			res_if.error_code !== want.error_code) begin
			mismatches++;
			if (mismatches <= 10)
				$display("request %0d: expected has=%0d byte=%02h ev=%0d op=%0d err=%0d, got has=%0d byte=%02h ev=%0d op=%0d err=%0d",
					res_seen, want.has_byte, want.out_byte, want.event_res, want.event_opcode,
					want.error_code, res_if.has_byte, res_if.out_byte, res_if.event_res,
					res_if.event_opcode, res_if.error_code);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snk_ready <= 1'b0;
			snk_wait <= 0;
			snk_calm <= 1'b0;
		end else begin
			if (res_if.valid && snk_ready) begin
				check_result();
				if ($urandom_range(0, 39) == 0) snk_calm <= !snk_calm;
				snk_next = snk_calm ? 0 : int'($urandom_range(0, 3));
			end else begin
				snk_next = (snk_wait == 0) ? 0 : snk_wait - 1;
			end
			snk_wait <= snk_next;
			snk_ready <= (snk_next == 0);
		end
	end

	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int         pick;
		int         fin;
		logic [3:0] op;
		logic [7:0] c;
		bit         paused;
		paused = 1'b0;

		// directed frames
		send_frame(OP_BINARY, 1'b0, 1'b0, 32'h0);
		text_q.push_back(8'hff);
		send_frame(OP_PING, 1'b0, 1'b0, 32'h0);
		push_text("/w== ");
		text_q.push_back(8'h00);
		send_frame(OP_TEXT, 1'b1, 1'b0, 32'hffff_ffff);
		push_text("AAAA");
		send_frame(OP_BINARY, 1'b1, 1'b1, 32'h0);

		while (tx_q.size() < 620) begin
			if (!paused && tx_q.size() > 300) begin
				paused = 1'b1;
				hold_sender();
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				add_b64(($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 9),
					($urandom_range(0, 2) == 0) ? 25 : 0);
				if ($urandom_range(0, 6) == 0) begin
					text_q.push_back(8'h00);
					repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom));
				end
				send_frame(data_op(), 1'b1, $urandom_range(0, 4) == 0, $urandom);
			end else if (pick < 88) begin
				do op = 4'($urandom); while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
				repeat ($urandom_range(0, 10)) text_q.push_back(8'($urandom));
				send_frame(op, 1'($urandom), $urandom_range(0, 3) == 0, $urandom);
			end else if (pick < 97) begin
				send_frame(data_op(), 1'($urandom), $urandom_range(0, 3) == 0, $urandom);
			end else begin
				hold_sender();
			end
		end

		// one frame that stops the block, then bytes it must ignore
		fin = $urandom_range(0, 8);
		case (fin)
			0: begin
				push_byte({4'($urandom), OP_CLOSE});
				push_byte(8'($urandom));
			end
			1: begin
				do op = 4'($urandom); while (op == OP_CLOSE);
				push_byte({4'($urandom), op});
				push_byte({1'($urandom), LEN_EXT64});
			end
			2: begin
				add_b64(3, 0);
				send_frame(data_op(), 1'b0, $urandom_range(0, 1), 32'h0);
			end
			default: begin
				add_b64(3 * $urandom_range(0, 2), 10);
				case (fin)
					3: begin
						do c = 8'($urandom);
						while (alphabet_index(c) >= 0 || c == "=" || c == 8'h00 || c == 8'h20 ||
							(c >= 8'h09 && c <= 8'h0d));
						text_q.push_back(c);
						push_text("AAAA");
					end
					4: push_text($urandom_range(0, 1) ? "A==" : "==");
					5: push_text($urandom_range(0, 1) ? "AA==A" : "AAA=B");
					6: push_text($urandom_range(0, 1) ? "AAA" : "A");
					7: push_text($urandom_range(0, 1) ? "AA=" : "AA= ");
					default: push_text($urandom_range(0, 1) ? "AB==" : "AAB=");
				endcase
				send_frame(data_op(), 1'b1, $urandom_range(0, 1), $urandom);
			end
		endcase
		repeat (8) push_byte(8'($urandom));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (tx_q.size() != 0 || src_valid || decoded_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (decoded_due.size() != 0) $display("%0d results never arrived", decoded_due.size());
		if (mismatches == 0 && decoded_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
